// ===== src/kway_merge_min_select_top_assert.svh =====
// Assertion macros for the k-way merge selector checks.
`ifndef KWAY_MERGE_MIN_SELECT_TOP_ASSERT_SVH
`define KWAY_MERGE_MIN_SELECT_TOP_ASSERT_SVH

// Same-cycle implication.
`define KMMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmms: assertion failed");

// Next-cycle implication.
`define KMMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmms: assertion failed");

`endif

// ===== src/kmms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kmms_pkg;

  localparam int KEY_W       = 32;
  localparam int RUN_W       = 3;
  // run + head_key + pick, padded to whole bytes
  localparam int IN_TDATA_W  = 40;
  // winner_run + winner_key, padded to whole bytes
  localparam int OUT_TDATA_W = 40;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_EMIT
  } kmms_state_t;

endpackage

`default_nettype wire

// ===== src/kway_merge_min_select_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// K-way merge winner selector. Holds one head key (signed Q16.16) and one
// live flag per run slot. Every input request updates one slot (load a key
// and mark it live, or mark it exhausted); a request with pick set then
// scans all RUNS slots and returns the live slot with the smallest key
// (largest when reverse_order is 1), lowest slot winning on ties, or
// found = 0 once every run is exhausted. A request with pick keeps the
// block busy through the scan, which reads the key memory one slot per
// cycle through a single comparator, and until the result is registered.
// The result sits in an output register, so a new request is taken while
// it waits. The key memory needs no clearing: only keys of live slots are
// used, and a slot only turns live when its key is written. The user must
// change reverse_order only while the block is idle; the block does not enforce it.
module kway_merge_min_select_top #(
  parameter int RUNS = 8
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // in_tdata, low bit up: run[2:0], head_key[34:3], pick[35], zero pad
  input  wire  [kmms_pkg::IN_TDATA_W-1:0]      in_tdata,
  // in_tuser: has_key
  input  wire                                  in_tuser,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // out_tdata, low bit up: winner_run[2:0], winner_key[34:3], zero pad
  output logic [kmms_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // out_tuser: found
  output logic                                 out_tuser,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // cfg_data: reverse_order
  input  wire                                  cfg_data,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready
);

  localparam int RIDX_W = (RUNS > 1) ? $clog2(RUNS) : 1;
  localparam int AW     = (RIDX_W > kmms_pkg::RUN_W) ? RIDX_W : kmms_pkg::RUN_W;

  // ---- request fields ----
  logic [kmms_pkg::RUN_W-1:0] in_run;
  kmms_pkg::key_t             in_key;
  logic                       in_pick;
  logic                       in_has_key;
  logic                       in_acc;
  logic [AW-1:0]              run_ext;
  logic                       run_ok;
  logic [RIDX_W-1:0]          wr_addr;

  assign in_run     = in_tdata[kmms_pkg::RUN_W-1:0];
  assign in_key     = in_tdata[kmms_pkg::RUN_W +: kmms_pkg::KEY_W];
  assign in_pick    = in_tdata[kmms_pkg::RUN_W + kmms_pkg::KEY_W];
  assign in_has_key = in_tuser;
  assign in_acc     = in_tvalid && in_tready;

  // slot index, widened so that out-of-range runs are seen and ignored
  assign run_ext = AW'(in_run);
  assign run_ok  = {1'b0, run_ext} < (AW+1)'(RUNS);
  assign wr_addr = run_ext[RIDX_W-1:0];

  // ---- configuration ----
  logic reverse_order_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_order_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      reverse_order_r <= cfg_data;
    end
  end

  // ---- sequencer ----
  kmms_pkg::kmms_state_t state_r, state_nxt;
  logic [RIDX_W-1:0]     cnt_r, cnt_nxt;
  logic                  rd_en;
  logic                  emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kmms_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_tready = 1'b0;
    rd_en     = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      kmms_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && in_pick) begin
          state_nxt = kmms_pkg::ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      kmms_pkg::ST_SCAN: begin
        rd_en   = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == RIDX_W'(RUNS-1)) begin
          state_nxt = kmms_pkg::ST_LAST;
        end
      end
      kmms_pkg::ST_LAST: begin
        // last slot is compared at this edge
        state_nxt = kmms_pkg::ST_EMIT;
      end
      kmms_pkg::ST_EMIT: begin
        if (!out_tvalid || out_tready) begin
          emit      = 1'b1;
          state_nxt = kmms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = kmms_pkg::ST_IDLE;
      end
    endcase
  end

  // ---- key memory, registered read ----
  kmms_pkg::key_t key_mem [RUNS];
  kmms_pkg::key_t rd_data_r;
  logic           rd_vld_r;
  logic [RIDX_W-1:0] rd_idx_r;

  always_ff @(posedge clk) begin
    if (in_acc && run_ok && in_has_key) begin
      key_mem[wr_addr] <= in_key;
    end
    if (rd_en) begin
      rd_data_r <= key_mem[cnt_r];
    end
    rd_idx_r <= cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

  // ---- live flags ----
  logic [RUNS-1:0] live_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (in_acc && run_ok) begin
      live_r[wr_addr] <= in_has_key;
    end
  end

  // ---- compare: strict, so ties keep the lower slot ----
  kmms_pkg::key_t    best_key_r;
  logic [RIDX_W-1:0] best_run_r;
  logic              best_found_r;
  logic              beats;
  logic              take;

  assign beats = reverse_order_r ? (rd_data_r > best_key_r) : (rd_data_r < best_key_r);
  assign take  = rd_vld_r && live_r[rd_idx_r] && (!best_found_r || beats);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
    end else if (in_acc && in_pick) begin
      best_found_r <= 1'b0;
    end else if (take) begin
      best_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_key_r <= rd_data_r;
      best_run_r <= rd_idx_r;
    end
  end

  // ---- output register ----
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [kmms_pkg::RUN_W-1:0] out_run_r;
  kmms_pkg::key_t         out_key_r;
  logic [AW-1:0]          best_run_ext;

  assign best_run_ext = AW'(best_run_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_found_r <= best_found_r;
      out_run_r   <= best_found_r ? best_run_ext[kmms_pkg::RUN_W-1:0] : '0;
      out_key_r   <= best_found_r ? best_key_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {
    (kmms_pkg::OUT_TDATA_W - kmms_pkg::KEY_W - kmms_pkg::RUN_W)'(0),
    out_key_r, out_run_r};

endmodule

`default_nettype wire

// ===== src/kmms_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "kway_merge_min_select_top_assert.svh"

module kmms_chk (
  input wire                              clk,
  input wire                              rst_n,
  input wire [kmms_pkg::IN_TDATA_W-1:0]   in_tdata,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire [kmms_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire                              out_tuser,
  input wire                              out_tvalid,
  input wire                              out_tready
);

  logic pick_acc;

  assign pick_acc = in_tvalid && in_tready && in_tdata[kmms_pkg::RUN_W + kmms_pkg::KEY_W];

  // a stalled result stays offered
  `KMMS_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  // and keeps its payload
  `KMMS_ASSERT_NXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready,
                   $stable(out_tdata) && $stable(out_tuser))
  // nothing found means zero run and zero key
  `KMMS_ASSERT_IMP(a_empty_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata == '0)
  // a pick request blocks further requests while the scan runs
  `KMMS_ASSERT_NXT(a_pick_busy, clk, rst_n, pick_acc, !in_tready)

endmodule

bind kway_merge_min_select_top kmms_chk u_kmms_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tdata   (in_tdata),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

// ===== test/tb_kway_merge_min_select_top.sv =====
`timescale 1ns / 1ps

module tb_kway_merge_min_select_top;

  localparam int RUNS = 8;
  localparam bit ORDER_ASCENDING  = 1'b0;
  localparam bit ORDER_DESCENDING = 1'b1;
  // generous margin for a pick's scan of all RUNS slots and for a plain update
  localparam int SETTLE_CYCLES = RUNS + 12;

  typedef logic [kmms_pkg::RUN_W-1:0] run_t;

  typedef struct packed {
    run_t             run;
    kmms_pkg::key_t   key;
    logic             found;
  } winner_t;

  // Tracks the slot state, predicts each pick and checks the results in order.
  class merge_winner_board;
    kmms_pkg::key_t head_key [RUNS];
    bit             run_live [RUNS];
    bit             reverse;
    winner_t        due_winners [$];
    winner_t        last_pick;
    int             errors;

    function new();
      for (int i = 0; i < RUNS; i++) begin
        head_key[i] = '0;
        run_live[i] = 1'b0;
      end
      reverse   = ORDER_ASCENDING;
      last_pick = '0;
      errors    = 0;
    endfunction

    function void note_request(run_t run, kmms_pkg::key_t key, logic has_key, logic pick);
      winner_t best;
      if (run < RUNS) begin
        if (has_key) head_key[run] = key;
        run_live[run] = has_key;
      end
      if (!pick) return;
      best = '0;
      // strict compare, so a tie keeps the lower slot
      for (int i = 0; i < RUNS; i++) begin
        if (run_live[i] && (!best.found ||
            (reverse ? head_key[i] > best.key : head_key[i] < best.key))) begin
          best.found = 1'b1;
          best.key   = head_key[i];
          best.run   = i[kmms_pkg::RUN_W-1:0];
        end
      end
      last_pick = best;
      due_winners.push_back(best);
    endfunction

    function void check_winner(logic [kmms_pkg::OUT_TDATA_W-1:0] tdata, logic found);
      winner_t want;
      if (due_winners.size() == 0) begin
        $display("%0t: result with none due: run %0d key %h found %b",
                 $time, tdata[2:0], tdata[34:3], found);
        errors++;
        return;
      end
      want = due_winners.pop_front();
      if (tdata[2:0] !== want.run) begin
        $display("%0t: winner_run expected %0d actual %0d", $time, want.run, tdata[2:0]);
        errors++;
      end
      if (tdata[34:3] !== want.key) begin
        $display("%0t: winner_key expected %h actual %h", $time, want.key, tdata[34:3]);
        errors++;
      end
      if (found !== want.found) begin
        $display("%0t: found expected %b actual %b", $time, want.found, found);
        errors++;
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic [kmms_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             in_tuser = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [kmms_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic                             cfg_data = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;

  merge_winner_board winners = new();
  int                results_seen = 0;
  bit                calm = 1'b0;

  kway_merge_min_select_top #(.RUNS(RUNS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  always #10 clk = ~clk;

  // Accepted requests and results, both seen at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        winners.note_request(in_tdata[2:0], in_tdata[34:3], in_tuser, in_tdata[35]);
      if (out_tvalid && out_tready) begin
        winners.check_winner(out_tdata, out_tuser);
        results_seen++;
      end
    end
  end

  // Alternate between stretches with no idling and stretches with gaps.
  initial begin
    forever begin
      repeat ($urandom_range(40, 200)) @(negedge clk);
      calm = ~calm;
    end
  end

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic kmms_pkg::key_t rand_key();
    case ($urandom_range(0, 9))
      0:       return kmms_pkg::key_t'(32'h8000_0000);
      1:       return kmms_pkg::key_t'(32'h7fff_ffff);
      2:       return $urandom_range(0, 1) ? kmms_pkg::key_t'(0) : kmms_pkg::key_t'(-1);
      3, 4, 5: return kmms_pkg::key_t'(int'($urandom_range(0, 8)) - 4);   // ties
      default: return kmms_pkg::key_t'($urandom);
    endcase
  endfunction

  // Result sink: random stalls, plus one long hold-off to back up the block.
  initial begin : result_sink
    int stall;
    bit held;
    held = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (!held && results_seen >= 40) begin
        held = 1'b1;
        out_tready = 1'b0;
        for (int c = 0; c < 300; c++) @(negedge clk);
      end
      stall = idle_len();
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance,
  // so the monitor has already noted the request.
  task automatic send_request(input run_t run, input kmms_pkg::key_t key,
                              input logic has_key, input logic pick);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {4'b0, pick, key, run};
    in_tuser  = has_key;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Idle the input, wait for every due result and any plain update in flight.
  task automatic drain();
    in_tvalid = 1'b0;
    while (winners.due_winners.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_order(input bit order);
    drain();
    cfg_data  = order;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    winners.reverse = order;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // A merge as software runs it: load the runs, then keep replacing the
  // winner's head with its next key, or retiring the run.
  task automatic run_merge(input int steps, inout int sent);
    winner_t w;
    longint  nk;
    for (int r = 0; r < RUNS; r++) begin
      send_request(r[kmms_pkg::RUN_W-1:0], rand_key(), $urandom_range(0, 5) != 0,
                   r == RUNS - 1);
      sent++;
    end
    for (int s = 0; s < steps; s++) begin
      w = winners.last_pick;
      if (!w.found) break;
      if ($urandom_range(0, 4) == 0) begin
        send_request(w.run, kmms_pkg::key_t'($urandom), 1'b0, 1'b1);
      end else begin
        nk = longint'(w.key);
        nk = winners.reverse ? nk - longint'($urandom_range(0, 196608))
                             : nk + longint'($urandom_range(0, 196608));
        if (nk > 64'sd2147483647)  nk = 64'sd2147483647;
        if (nk < -64'sd2147483648) nk = -64'sd2147483648;
        send_request(w.run, kmms_pkg::key_t'(nk), 1'b1, 1'b1);
      end
      sent++;
    end
  endtask

  task automatic random_phase(input int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        // noise: any slot, any key, any flags
        send_request(run_t'($urandom_range(0, 7)), rand_key(),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        run_merge($urandom_range(4, 20), sent);
      end
    end
  endtask

  initial begin : stimulus
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // ascending order from reset
    send_request(3'd0, kmms_pkg::key_t'(32'h0000_1234), 1'b0, 1'b1);  // nothing live
    send_request(3'd3, kmms_pkg::key_t'(32'h7fff_ffff), 1'b1, 1'b1);
    send_request(3'd5, kmms_pkg::key_t'(32'h8000_0000), 1'b1, 1'b0);  // update only
    send_request(3'd1, kmms_pkg::key_t'(0),             1'b1, 1'b1);
    send_request(3'd6, kmms_pkg::key_t'(32'h8000_0000), 1'b1, 1'b1);  // tie, slot 5 stays
    send_request(3'd5, kmms_pkg::key_t'(32'h1234_5678), 1'b0, 1'b1);
    send_request(3'd0, kmms_pkg::key_t'(-1),            1'b1, 1'b1);
    send_request(3'd6, kmms_pkg::key_t'(0),             1'b0, 1'b1);
    send_request(3'd7, kmms_pkg::key_t'(32'h0001_0000), 1'b1, 1'b0);
    send_request(3'd2, kmms_pkg::key_t'(32'h0001_0000), 1'b1, 1'b1);
    for (int r = 0; r < RUNS; r++)
      send_request(r[kmms_pkg::RUN_W-1:0], kmms_pkg::key_t'(32'hffff_ffff), 1'b0,
                   r == RUNS - 1);

    // descending order, extremes and ties
    write_order(ORDER_DESCENDING);
    send_request(3'd4, kmms_pkg::key_t'(32'h8000_0000), 1'b1, 1'b1);
    send_request(3'd2, kmms_pkg::key_t'(32'h7fff_ffff), 1'b1, 1'b1);
    send_request(3'd7, kmms_pkg::key_t'(32'h7fff_ffff), 1'b1, 1'b1);
    send_request(3'd2, kmms_pkg::key_t'(0),             1'b0, 1'b1);
    send_request(3'd7, kmms_pkg::key_t'(0),             1'b0, 1'b1);
    send_request(3'd4, kmms_pkg::key_t'(0),             1'b0, 1'b1);

    random_phase(160);
    write_order(ORDER_ASCENDING);
    random_phase(170);
    write_order(ORDER_DESCENDING);
    random_phase(170);

    drain();
    if (winners.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(20_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/kmms_pkg.sv
src/kway_merge_min_select_top.sv
src/kmms_chk.sv
test/tb_kway_merge_min_select_top.sv
